// ===== rtl/tzfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tzfr_pkg
// Shared types and constants of the multizone frame reducer.
// ----------------------------------------------------------------------------
package tzfr_pkg;

    localparam int MAX_ZONES   = 64;
    localparam int SMALL_ZONES = 16;
    localparam int ZW          = $clog2(MAX_ZONES);

    // reduction modes
    localparam logic [2:0] MODE_SINGLE  = 3'd0;
    localparam logic [2:0] MODE_AVERAGE = 3'd1;
    localparam logic [2:0] MODE_NEAR    = 3'd2;
    localparam logic [2:0] MODE_FAR     = 3'd3;
    localparam logic [2:0] MODE_CENTRE  = 3'd4;

    // data selects
    localparam logic [2:0] SEL_DIST  = 3'd0;
    localparam logic [2:0] SEL_SIGMA = 3'd1;
    localparam logic [2:0] SEL_REFL  = 3'd2;
    localparam logic [2:0] SEL_COUNT = 3'd3;
    localparam logic [2:0] SEL_TEMP  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SEL   = 2'd1;
    localparam logic [1:0] REG_ZONE  = 2'd2;
    localparam logic [1:0] REG_GRID  = 2'd3;

    // result status
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NOVALID = 2'd2;

    localparam logic [23:0] Q8_MAX = 24'h7FFFFF;

    // what the front hands to the back per frame
    typedef enum logic [2:0] {
        K_DIRECT = 3'b001,  // value/status are final
        K_DIVIDE = 3'b010,  // (num)/den, then maybe root
        K_ROOT   = 3'b100   // root of num
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        do_root;
        logic [55:0] num;
        logic [6:0]  den;
        logic [23:0] value;
        logic [1:0]  status;
    } t_job;

    function automatic logic [23:0] sat_q8(input logic [63:0] v);
        sat_q8 = (v > {40'd0, Q8_MAX}) ? Q8_MAX : v[23:0];
    endfunction

endpackage : tzfr_pkg
`default_nettype wire

// ===== rtl/tzfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tzfr_front
// Accumulates zones of one frame and closes it into a job for the back end.
// ----------------------------------------------------------------------------
module tzfr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [13:0]     i_distance_mm,
    input  wire logic [7:0]      i_target_state,
    input  wire logic [15:0]     i_sigma_mm,
    input  wire logic [7:0]      i_reflect_pct,
    input  wire logic [3:0]      i_targets_seen,
    input  wire logic [7:0]      i_die_temp_c,
    output logic                 o_job_valid,
    output tzfr_pkg::t_job       o_job,
    input  wire logic            i_job_ready
);
    import tzfr_pkg::*;

    logic [2:0]  r_mode, r_sel;
    logic [7:0]  r_zone;
    logic        r_grid;
    logic [ZW-1:0] r_cnt;
    logic [39:0] r_sum;
    logic [6:0]  r_vcnt;
    logic [13:0] r_bdist;
    logic [15:0] r_bdatum;
    logic        r_bfound;
    logic [15:0] r_sdatum;
    logic        r_svalid;
    logic [33:0] r_csum;
    logic        r_cinv;

    logic        acc, dvalid, zone_ok, last, centre;
    logic [15:0] datum;
    logic [31:0] sq;
    logic [6:0]  total;
    logic [39:0] sum_n;
    logic [6:0]  vcnt_n;
    logic [33:0] csum_n;
    logic        bfound_n, svalid_n, cinv_n;
    logic [15:0] bdatum_n, sdatum_n;
    t_job        job;

    assign o_ready = i_job_ready;
    assign acc     = i_valid && o_ready;
    assign total   = r_grid ? 7'(MAX_ZONES) : 7'(SMALL_ZONES);
    assign dvalid  = (i_target_state == 8'd5) || (i_target_state == 8'd6) ||
                     (i_target_state == 8'd9);
    assign last    = {1'b0, r_cnt} >= total - 7'd1;

    // pick the datum of this zone
    always_comb begin
        case (r_sel)
            SEL_DIST:  datum = {2'd0, i_distance_mm};
            SEL_SIGMA: datum = i_sigma_mm;
            SEL_REFL:  datum = {8'd0, i_reflect_pct};
            SEL_COUNT: datum = {12'd0, i_targets_seen};
            default:   datum = '0;
        endcase
        zone_ok = (r_sel == SEL_DIST) ? dvalid : (r_sel <= SEL_COUNT);
        sq      = (r_sel == SEL_SIGMA) ? i_sigma_mm * i_sigma_mm : {16'd0, datum};
        if (r_grid)
            centre = (r_cnt == ZW'(27)) || (r_cnt == ZW'(28)) ||
                     (r_cnt == ZW'(35)) || (r_cnt == ZW'(36));
        else
            centre = (r_cnt == ZW'(5)) || (r_cnt == ZW'(6)) ||
                     (r_cnt == ZW'(9)) || (r_cnt == ZW'(10));
    end

    // accumulate this zone
    always_comb begin
        sum_n = r_sum; vcnt_n = r_vcnt; csum_n = r_csum;
        bfound_n = r_bfound; bdatum_n = r_bdatum;
        svalid_n = r_svalid; sdatum_n = r_sdatum; cinv_n = r_cinv;
        case (r_mode)
            MODE_SINGLE: begin
                if ({2'd0, r_cnt} == r_zone) begin
                    sdatum_n = datum; svalid_n = zone_ok;
                end
            end
            MODE_AVERAGE: begin
                if (zone_ok) begin
                    sum_n = r_sum + {8'd0, sq}; vcnt_n = r_vcnt + 7'd1;
                end
            end
            MODE_NEAR, MODE_FAR: begin
                if (dvalid && (!r_bfound || ((r_mode == MODE_NEAR) ?
                    i_distance_mm < r_bdist : i_distance_mm > r_bdist))) begin
                    bfound_n = 1'b1; bdatum_n = datum;
                end
            end
            MODE_CENTRE: begin
                if (centre) begin
                    csum_n = r_csum + {2'd0, sq};
                    if (!zone_ok) cinv_n = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // close the frame
    always_comb begin
        job = '0;
        job.kind = K_DIRECT;
        job.status = ST_VALID;
        if (r_sel == SEL_TEMP) begin
            job.value = {{8{i_die_temp_c[7]}}, i_die_temp_c, 8'd0};
        end else if (r_sel > SEL_TEMP) begin
            job.status = ST_NOVALID;
        end else begin
            case (r_mode)
                MODE_SINGLE: begin
                    if ({1'b0, r_zone} >= {2'd0, total}) job.status = ST_RANGE;
                    else if (!svalid_n) job.status = ST_NOVALID;
                    else job.value = sat_q8({40'd0, sdatum_n, 8'd0});
                end
                MODE_AVERAGE: begin
                    if (vcnt_n == 7'd0) job.status = ST_NOVALID;
                    else begin
                        job.kind = K_DIVIDE;
                        job.den  = vcnt_n;
                        if (r_sel == SEL_SIGMA) begin
                            job.do_root = 1'b1;
                            job.num = {sum_n, 16'd0};
                        end else
                            job.num = {8'd0, sum_n, 8'd0} + {49'd0, vcnt_n >> 1};
                    end
                end
                MODE_NEAR, MODE_FAR: begin
                    if (!bfound_n) job.status = ST_NOVALID;
                    else job.value = sat_q8({40'd0, bdatum_n, 8'd0});
                end
                MODE_CENTRE: begin
                    if (cinv_n) job.status = ST_NOVALID;
                    else if (r_sel == SEL_SIGMA) begin
                        job.kind = K_ROOT;
                        job.num  = {8'd0, csum_n, 14'd0};
                    end else
                        job.value = sat_q8({24'd0, csum_n, 6'd0});
                end
                default: job.status = ST_NOVALID;
            endcase
        end
    end

    // register the job towards the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_job_valid <= 1'b0;
        else o_job_valid <= acc && last;
        o_job <= job;
    end

    // frame state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_sel <= '0; r_zone <= '0; r_grid <= 1'b0;
            r_cnt <= '0; r_sum <= '0; r_vcnt <= '0; r_bdist <= '0;
            r_bdatum <= '0; r_bfound <= 1'b0; r_sdatum <= '0;
            r_svalid <= 1'b0; r_csum <= '0; r_cinv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: r_mode <= i_cfg_data[2:0];
                    REG_SEL:  r_sel  <= i_cfg_data[2:0];
                    REG_ZONE: r_zone <= i_cfg_data;
                    REG_GRID: r_grid <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (acc) begin
                if (last) begin
                    r_cnt <= '0; r_sum <= '0; r_vcnt <= '0; r_bdist <= '0;
                    r_bdatum <= '0; r_bfound <= 1'b0; r_sdatum <= '0;
                    r_svalid <= 1'b0; r_csum <= '0; r_cinv <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + ZW'(1);
                    r_sum <= sum_n; r_vcnt <= vcnt_n; r_csum <= csum_n;
                    r_bfound <= bfound_n; r_bdatum <= bdatum_n;
                    r_svalid <= svalid_n; r_sdatum <= sdatum_n; r_cinv <= cinv_n;
                    if (bfound_n && !(r_bfound && bdatum_n == r_bdatum &&
                        r_mode != MODE_NEAR && r_mode != MODE_FAR))
                        r_bdist <= (bfound_n != r_bfound ||
                                    (r_mode == MODE_NEAR ? i_distance_mm < r_bdist
                                                         : i_distance_mm > r_bdist))
                                   && dvalid ? i_distance_mm : r_bdist;
                end
            end
        end
    end
endmodule : tzfr_front
`default_nettype wire

// ===== rtl/tzfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tzfr_back
// Two-entry job queue, then a bit-serial divider and square root per frame.
// ----------------------------------------------------------------------------
module tzfr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_valid,
    input  tzfr_pkg::t_job       i_job,
    output logic                 o_job_ready,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [23:0]          o_frame_value_q8,
    output logic [1:0]           o_frame_status
);
    import tzfr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_DIV = 4'b0010, S_ROOT = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_job        r_q [2];
    logic [1:0]  r_fill;
    logic        r_wp, r_rp;
    t_state      r_st;
    logic [55:0] r_rem, r_quo, r_v, r_r, r_bit;
    logic [6:0]  r_den;
    logic        r_root;
    logic [5:0]  r_i;
    logic        pop, push;
    logic [56:0] trial;
    logic [55:0] rb;
    t_job        head;

    // keep one slot free while a job is in flight upstream
    assign o_job_ready = (r_fill == 2'd0);
    assign push = i_job_valid;
    assign head = r_q[r_rp];
    assign pop  = (r_st == S_IDLE) && (r_fill != 2'd0);
    assign trial = {r_rem, r_quo[55]} ;
    assign rb = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_wp <= 1'b0; r_rp <= 1'b0; r_st <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            case (r_st)
                S_IDLE: begin
                    if (pop) begin
                        o_frame_value_q8 <= head.value;
                        o_frame_status   <= head.status;
                        r_root <= head.do_root;
                        r_den  <= head.den;
                        r_quo  <= head.num;
                        r_rem  <= '0;
                        r_i    <= '0;
                        r_v    <= head.num;
                        r_r    <= '0;
                        r_bit  <= 56'd1 << 54;
                        case (head.kind)
                            K_DIVIDE: r_st <= S_DIV;
                            K_ROOT:   r_st <= S_ROOT;
                            default: begin
                                r_st <= S_OUT; o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                // restoring divide, one quotient bit a cycle
                S_DIV: begin
                    if (trial >= {50'd0, r_den}) begin
                        r_rem <= 56'(trial - {50'd0, r_den});
                        r_quo <= {r_quo[54:0], 1'b1};
                    end else begin
                        r_rem <= trial[55:0];
                        r_quo <= {r_quo[54:0], 1'b0};
                    end
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'd55) begin
                        if (r_root) begin
                            r_v <= {r_quo[54:0], trial >= {50'd0, r_den}};
                            r_st <= S_ROOT;
                        end else begin
                            o_frame_value_q8 <= sat_q8({8'd0, r_quo[54:0],
                                                trial >= {50'd0, r_den}});
                            o_valid <= 1'b1; r_st <= S_OUT;
                        end
                    end
                end
                // digit-by-digit root, two bits a cycle
                S_ROOT: begin
                    if (r_v >= rb) begin
                        r_v <= r_v - rb; r_r <= (r_r >> 1) + r_bit;
                    end else
                        r_r <= r_r >> 1;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 56'd1) begin
                        o_frame_value_q8 <= sat_q8({8'd0, (r_v >= rb) ?
                                            (r_r >> 1) + r_bit : r_r >> 1});
                        o_valid <= 1'b1; r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0; r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule : tzfr_back
`default_nettype wire

// ===== rtl/tof_zone_frame_reducer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tof_zone_frame_reducer_core
// Reduces each multizone range frame to one saturated Q.8 value.
// ----------------------------------------------------------------------------
// Zones enter on the i_valid/o_ready channel in raster order, 16 or 64 per
// frame; one zone a cycle is taken while the job queue has room. After the
// final zone of a frame one result leaves on o_valid/i_ready carrying
// o_frame_value_q8 and o_frame_status. Configuration is a write port
// (i_cfg_we, i_cfg_idx, i_cfg_data) used while the block is idle; the
// block itself does not enforce this. A direct result goes straight out;
// an average runs the 56-step serial divider, a root the 28-step square
// root, and the sigma average both in turn. The back end holds one frame
// at a time; while a job waits in its queue the front stalls until the
// back end is idle and takes it. When the receiver stalls, the result
// holds and the front keeps taking zones until a job waits in the queue.
// Synchronous reset clears configuration, counters, queue fill and state.
// ----------------------------------------------------------------------------
module tof_zone_frame_reducer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [13:0] i_distance_mm,
    input  wire logic [7:0]  i_target_state,
    input  wire logic [15:0] i_sigma_mm,
    input  wire logic [7:0]  i_reflect_pct,
    input  wire logic [3:0]  i_targets_seen,
    input  wire logic [7:0]  i_die_temp_c,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_frame_value_q8,
    output logic [1:0]       o_frame_status
);
    import tzfr_pkg::*;

    logic jv, jr;
    t_job job;

    tzfr_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_distance_mm, .i_target_state, .i_sigma_mm,
        .i_reflect_pct, .i_targets_seen, .i_die_temp_c,
        .o_job_valid(jv), .o_job(job), .i_job_ready(jr)
    );

    tzfr_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .i_job(job), .o_job_ready(jr),
        .o_valid, .i_ready, .o_frame_value_q8, .o_frame_status
    );
endmodule : tof_zone_frame_reducer_core
`default_nettype wire

// ===== verif/tof_zone_frame_reducer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_zone_frame_reducer_checker
// Watches the zone and result channels of the frame reducer, predicts each
// frame result from the accepted zones and the register writes, and compares
// the results in order.
// ----------------------------------------------------------------------------
module tof_zone_frame_reducer_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic [13:0] i_distance_mm,
    input  wire logic [7:0]  i_target_state,
    input  wire logic [15:0] i_sigma_mm,
    input  wire logic [7:0]  i_reflect_pct,
    input  wire logic [3:0]  i_targets_seen,
    input  wire logic [7:0]  i_die_temp_c,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [23:0] i_frame_value_q8,
    input  wire logic [1:0]  i_frame_status,
    output int               o_errors,
    output int               o_pending
);
    import tzfr_pkg::*;

    typedef struct packed {
        logic [23:0] value;
        logic [1:0]  status;
    } t_frame_res;

    t_frame_res frame_q[$];

    logic [2:0]  cfg_mode, cfg_sel;
    logic [7:0]  cfg_zone;
    logic        cfg_large;
    logic [5:0]  zone_cnt;
    logic [39:0] sum_acc;
    logic [6:0]  n_valid;
    logic [13:0] best_dist;
    logic [15:0] best_val;
    logic        best_seen;
    logic [15:0] pick_val;
    logic        pick_ok;
    logic [33:0] mid_sum;
    logic        mid_bad;
    logic [7:0]  last_temp;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] clip(input logic [63:0] v);
        return (v > 64'd8388607) ? 24'h7FFFFF : v[23:0];
    endfunction

    function automatic logic is_mid(input logic [5:0] idx, input logic big);
        if (big) return idx == 27 || idx == 28 || idx == 35 || idx == 36;
        return idx == 5 || idx == 6 || idx == 9 || idx == 10;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        o_errors++;
    endtask

    // predict on each accepted zone, compare on each accepted result
    always @(posedge i_clk) begin
        logic [6:0]  total;
        logic        dok, zok;
        logic [15:0] datum;
        logic [63:0] sq;
        t_frame_res  r, e;
        if (!i_rst_n) begin
            cfg_mode = MODE_SINGLE; cfg_sel = SEL_DIST; cfg_zone = 0; cfg_large = 0;
            zone_cnt = 0; sum_acc = 0; n_valid = 0; best_dist = 0; best_val = 0;
            best_seen = 0; pick_val = 0; pick_ok = 0; mid_sum = 0; mid_bad = 0;
            last_temp = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: cfg_mode = i_cfg_data[2:0];
                    REG_SEL:  cfg_sel = i_cfg_data[2:0];
                    REG_ZONE: cfg_zone = i_cfg_data;
                    REG_GRID: cfg_large = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                r.value = i_frame_value_q8;
                r.status = i_frame_status;
                if (frame_q.size() == 0) begin
                    report("unexpected result", r, 0);
                end else begin
                    e = frame_q.pop_front();
                    if (r.value !== e.value) report("value", r.value, e.value);
                    if (r.status !== e.status) report("status", r.status, e.status);
                end
            end
            if (i_valid && i_ready_in) begin
                total = cfg_large ? 7'd64 : 7'd16;
                dok = i_target_state == 5 || i_target_state == 6 || i_target_state == 9;
                case (cfg_sel)
                    SEL_DIST:  datum = 16'(i_distance_mm);
                    SEL_SIGMA: datum = i_sigma_mm;
                    SEL_REFL:  datum = 16'(i_reflect_pct);
                    SEL_COUNT: datum = 16'(i_targets_seen);
                    default:   datum = 0;
                endcase
                zok = (cfg_sel == SEL_DIST) ? dok : (cfg_sel <= SEL_COUNT);
                sq = (cfg_sel == SEL_SIGMA) ? 64'(i_sigma_mm) * i_sigma_mm : 64'(datum);
                last_temp = i_die_temp_c;
                case (cfg_mode)
                    MODE_SINGLE: if ({2'b0, zone_cnt} == cfg_zone) begin
                        pick_val = datum; pick_ok = zok;
                    end
                    MODE_AVERAGE: if (zok) begin
                        sum_acc = sum_acc + sq[39:0];
                        n_valid = n_valid + 7'd1;
                    end
                    MODE_NEAR, MODE_FAR: if (dok && (!best_seen ||
                            (cfg_mode == MODE_NEAR ? i_distance_mm < best_dist
                                                   : i_distance_mm > best_dist))) begin
                        best_dist = i_distance_mm; best_val = datum; best_seen = 1;
                    end
                    MODE_CENTRE: if (is_mid(zone_cnt, cfg_large)) begin
                        mid_sum = mid_sum + sq[33:0];
                        if (!zok) mid_bad = 1;
                    end
                    default: ;
                endcase
                if ({1'b0, zone_cnt} < total - 7'd1) begin
                    zone_cnt = zone_cnt + 6'd1;
                end else begin
                    e.value = 0;
                    e.status = ST_VALID;
                    if (cfg_sel == SEL_TEMP) begin
                        e.value = {{8{last_temp[7]}}, last_temp, 8'd0};
                    end else if (cfg_sel > SEL_TEMP) begin
                        e.status = ST_NOVALID;
                    end else begin
                        case (cfg_mode)
                            MODE_SINGLE:
                                if ({1'b0, cfg_zone} >= {2'b0, total}) e.status = ST_RANGE;
                                else if (!pick_ok) e.status = ST_NOVALID;
                                else e.value = clip(64'(pick_val) << 8);
                            MODE_AVERAGE:
                                if (n_valid == 0) e.status = ST_NOVALID;
                                else if (cfg_sel == SEL_SIGMA)
                                    e.value = clip(isqrt((64'(sum_acc) << 16) / n_valid));
                                else
                                    e.value = clip(((64'(sum_acc) << 8) + n_valid / 2)
                                                   / n_valid);
                            MODE_NEAR, MODE_FAR:
                                if (!best_seen) e.status = ST_NOVALID;
                                else e.value = clip(64'(best_val) << 8);
                            MODE_CENTRE:
                                if (mid_bad) e.status = ST_NOVALID;
                                else if (cfg_sel == SEL_SIGMA)
                                    e.value = clip(isqrt(64'(mid_sum) << 14));
                                else e.value = clip(64'(mid_sum) << 6);
                            default: e.status = ST_NOVALID;
                        endcase
                    end
                    frame_q.push_back(e);
                    zone_cnt = 0; sum_acc = 0; n_valid = 0; best_dist = 0; best_val = 0;
                    best_seen = 0; pick_val = 0; pick_ok = 0; mid_sum = 0; mid_bad = 0;
                end
            end
            o_pending = frame_q.size();
        end
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    final begin
        // nothing
    end

endmodule

// ===== verif/tof_zone_frame_reducer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_zone_frame_reducer_core_tb
// Drives directed and random frames under many register settings into the
// frame reducer, with random idling on both channels; a checker module
// predicts and compares every frame result.
// ----------------------------------------------------------------------------
module tof_zone_frame_reducer_core_tb;
    import tzfr_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = REG_MODE;
    logic [7:0]  i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [13:0] i_distance_mm = 0;
    logic [7:0]  i_target_state = 0;
    logic [15:0] i_sigma_mm = 0;
    logic [7:0]  i_reflect_pct = 0;
    logic [3:0]  i_targets_seen = 0;
    logic [7:0]  i_die_temp_c = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [23:0] o_frame_value_q8;
    logic [1:0]  o_frame_status;

    int errors, pending, zones_sent, idle_cycles;
    logic quiet;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    tof_zone_frame_reducer_core DUT (.*);

    tof_zone_frame_reducer_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_ready_in(o_ready), .i_distance_mm, .i_target_state, .i_sigma_mm,
        .i_reflect_pct, .i_targets_seen, .i_die_temp_c, .i_res_valid(o_valid),
        .i_res_ready(i_ready), .i_frame_value_q8(o_frame_value_q8),
        .i_frame_status(o_frame_status),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog: count cycles without any accepted item, reset or register write
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result sink: random stall bursts unless quiet
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                i_ready <= 0;
                repeat (n) @(negedge i_clk);
            end
            i_ready <= 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_all(input logic [2:0] mode, input logic [2:0] sel,
                           input logic [7:0] zone, input logic big_grid);
        write_reg(REG_MODE, {5'd0, mode});
        write_reg(REG_SEL, {5'd0, sel});
        write_reg(REG_ZONE, zone);
        write_reg(REG_GRID, {7'd0, big_grid});
    endtask

    // hold until every result has come, then let the back end settle
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // send one zone, held until accepted; kind 0 random, 1 all zero but die temp -128, 2 all max with state 9
    task automatic send_zone(input int kind, input int valid_pct);
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 10);
            i_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1;
        case (kind)
            1: begin
                i_distance_mm <= 0; i_target_state <= 0; i_sigma_mm <= 0;
                i_reflect_pct <= 0; i_targets_seen <= 0; i_die_temp_c <= 8'h80;
            end
            2: begin
                i_distance_mm <= '1; i_target_state <= 8'd9; i_sigma_mm <= '1;
                i_reflect_pct <= '1; i_targets_seen <= '1; i_die_temp_c <= 8'h7F;
            end
            default: begin
                i_distance_mm <= ($urandom_range(0, 3) == 0) ? 14'($urandom)
                                                            : 14'($urandom_range(0, 4000));
                if ($urandom_range(0, 99) < valid_pct) begin
                    case ($urandom_range(0, 2))
                        0: i_target_state <= 8'd5;
                        1: i_target_state <= 8'd6;
                        default: i_target_state <= 8'd9;
                    endcase
                end else begin
                    i_target_state <= 8'($urandom);
                end
                i_sigma_mm <= 16'($urandom);
                i_reflect_pct <= 8'($urandom);
                i_targets_seen <= 4'($urandom);
                i_die_temp_c <= 8'($urandom);
            end
        endcase
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        zones_sent++;
        @(negedge i_clk);
    endtask

    // send a whole frame, then drop valid
    task automatic send_frame(input logic big_grid, input int kind, input int valid_pct);
        for (int z = 0; z < (big_grid ? 64 : 16); z++) send_zone(kind, valid_pct);
        i_valid <= 0;
    endtask

    initial begin
        logic big_grid;
        zones_sent = 0;
        idle_cycles = 0;
        quiet = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, single, average and centre modes, out-of-range zone, bad select
        set_all(MODE_SINGLE, SEL_DIST, 8'd15, 1'b0);
        send_frame(1'b0, 2, 100);
        drain();
        set_all(MODE_AVERAGE, SEL_SIGMA, 8'd255, 1'b1);
        send_frame(1'b1, 2, 100);
        drain();
        set_all(MODE_CENTRE, SEL_SIGMA, 8'd16, 1'b0);
        send_frame(1'b0, 1, 100);
        drain();
        write_reg(REG_MODE, {5'd0, MODE_SINGLE});
        send_frame(1'b0, 0, 100);
        drain();
        write_reg(REG_SEL, 8'd7);
        write_reg(REG_MODE, 8'd7);
        send_frame(1'b0, 0, 50);
        drain();

        // random frames, mostly small grid
        while (zones_sent < 1950) begin
            big_grid = ($urandom_range(0, 5) == 0);
            if (zones_sent > 1700) quiet = 1;
            set_all(3'($urandom_range(0, 5)),
                    ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4)),
                    ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, big_grid ? 63 : 15)),
                    big_grid);
            send_frame(big_grid, 0, $urandom_range(0, 3) == 0 ? 5 : 80);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tzfr_pkg.sv
rtl/tzfr_front.sv
rtl/tzfr_back.sv
rtl/tof_zone_frame_reducer_core.sv
verif/tof_zone_frame_reducer_checker.sv
verif/tof_zone_frame_reducer_core_tb.sv
